// ===== src/fraction_product_reducer_defines.svh =====
// Assertion macros for the fraction product reducer.
// Each check is sampled on the rising edge of clk and is switched off while rst is high.
// Defining NO_ASSERTIONS turns every check into an empty line.
`ifndef FRACTION_PRODUCT_REDUCER_DEFINES_SVH
`define FRACTION_PRODUCT_REDUCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks cons in the same cycle that ante holds.
`define FPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpr: assertion failed");

// Checks cons in the cycle after ante holds.
`define FPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpr: assertion failed");

`else

`define FPR_ASSERT_IMP(label, ante, cons)
`define FPR_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/fpr_pkg.sv =====
`default_nettype none
package fpr_pkg;

  localparam int FACTOR_WIDTH = 16;
  localparam int ACC_WIDTH    = 32;

  // magnitude cap of the exact product
  localparam logic [63:0] CAP64 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_ZERO = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic gcd_load;
    logic gcd_step;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic zero_num;
    logic gcd_done;
    logic div_last;
    logic last;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/fpr_ctrl.sv =====
`default_nettype none
module fpr_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  fpr_pkg::sts_t  sts,
  output fpr_pkg::cmd_t  cmd
);

  fpr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpr_pkg::ST_IDLE: begin
        if (in_valid) state_next = fpr_pkg::ST_MUL;
      end
      fpr_pkg::ST_MUL: begin
        if (sts.mul_last) state_next = fpr_pkg::ST_PREP;
      end
      fpr_pkg::ST_PREP: begin
        state_next = sts.zero_num ? fpr_pkg::ST_COMMIT : fpr_pkg::ST_GCD;
      end
      fpr_pkg::ST_GCD: begin
        if (sts.gcd_done) state_next = fpr_pkg::ST_DIV;
      end
      fpr_pkg::ST_DIV: begin
        if (sts.div_last) state_next = fpr_pkg::ST_COMMIT;
      end
      fpr_pkg::ST_COMMIT: begin
        // a final result waits for a free output register
        if (!sts.last || !sts.out_busy) state_next = fpr_pkg::ST_IDLE;
      end
      default: begin
        state_next = fpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      fpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fpr_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      fpr_pkg::ST_PREP: begin
        cmd.gcd_load = 1'b1;
      end
      fpr_pkg::ST_GCD: begin
        cmd.gcd_step = !sts.gcd_done;
      end
      fpr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      fpr_pkg::ST_COMMIT: begin
        cmd.commit = !sts.last || !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/fpr_dp.sv =====
`default_nettype none
`include "fraction_product_reducer_defines.svh"
module fpr_dp #(
  parameter int FACTOR_WIDTH = fpr_pkg::FACTOR_WIDTH,
  parameter int ACC_WIDTH    = fpr_pkg::ACC_WIDTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  fpr_pkg::cmd_t           cmd,
  output fpr_pkg::sts_t           sts,
  input  wire  [FACTOR_WIDTH-1:0] in_num,
  input  wire  [FACTOR_WIDTH-1:0] in_den,
  input  wire                     in_last,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [ACC_WIDTH-1:0]    out_num,
  output logic [ACC_WIDTH-1:0]    out_den,
  output logic [1:0]              out_status
);

  localparam int PW = ACC_WIDTH + FACTOR_WIDTH;   // exact product width
  localparam int GW = (PW > 63) ? 63 : PW;        // width after the 2^63-1 cap
  localparam int XW = (PW > 64) ? PW : 64;
  localparam int EW = (GW > ACC_WIDTH) ? GW : ACC_WIDTH;
  localparam int KW = $clog2(GW);
  localparam int CW = $clog2(GW + 1);

  // running product
  logic [ACC_WIDTH-1:0] acc_num, acc_den;
  logic [1:0]           err;

  // per-word state
  logic [PW-1:0]           mcn, mcd, prn, prd;
  logic [FACTOR_WIDTH-1:0] mpn, mpd;
  logic                    sgn_n, sgn_d, zden, znum, lastf, ovf;
  logic [CW-1:0]           cnt;

  logic [GW-1:0] ga, gb, g;
  logic [KW-1:0] gk;
  logic          gdone;

  logic [GW-1:0] qn, qd;
  logic [GW:0]   rn, rd;

  // magnitudes of the operands
  logic                    an_neg, ad_neg, fn_neg, fd_neg;
  logic [ACC_WIDTH-1:0]    anm, adm;
  logic [FACTOR_WIDTH-1:0] fnm, fdm;

  assign an_neg = acc_num[ACC_WIDTH-1];
  assign ad_neg = acc_den[ACC_WIDTH-1];
  assign fn_neg = in_num[FACTOR_WIDTH-1];
  assign fd_neg = in_den[FACTOR_WIDTH-1];
  assign anm    = an_neg ? (~acc_num + 1'b1) : acc_num;
  assign adm    = ad_neg ? (~acc_den + 1'b1) : acc_den;
  assign fnm    = fn_neg ? (~in_num + 1'b1) : in_num;
  assign fdm    = fd_neg ? (~in_den + 1'b1) : in_den;

  // product cap
  logic          cap_n, cap_d;
  logic [GW-1:0] cpn, cpd;

  assign cap_n = XW'(prn) > XW'(fpr_pkg::CAP64);
  assign cap_d = XW'(prd) > XW'(fpr_pkg::CAP64);
  assign cpn   = cap_n ? GW'(fpr_pkg::CAP64) : GW'(prn);
  assign cpd   = cap_d ? GW'(fpr_pkg::CAP64) : GW'(prd);

  // one restoring division step, returns {remainder, quotient}
  function automatic logic [2*GW:0] div_bit(logic [GW:0] r, logic [GW-1:0] q,
                                            logic [GW-1:0] d);
    logic [GW:0] rs;
    rs = {r[GW-1:0], q[GW-1]};
    if (rs >= {1'b0, d}) begin
      div_bit = {rs - {1'b0, d}, q[GW-2:0], 1'b1};
    end else begin
      div_bit = {rs, q[GW-2:0], 1'b0};
    end
  endfunction

  // saturate a magnitude to the accumulator range and apply the sign
  function automatic logic [ACC_WIDTH:0] encode(logic [GW-1:0] mag, logic neg);
    logic [ACC_WIDTH-1:0] lim, m;
    logic                 sat;
    lim = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    sat = EW'(mag) > EW'(lim);
    m   = sat ? lim : ACC_WIDTH'(mag);
    encode = {sat, neg ? (~m + 1'b1) : m};
  endfunction

  logic [2*GW:0]    dvn, dvd;
  logic [ACC_WIDTH:0] enc_n, enc_d;

  assign dvn   = div_bit(rn, qn, g);
  assign dvd   = div_bit(rd, qd, g);
  assign enc_n = encode(qn, sgn_n);
  assign enc_d = encode(qd, sgn_d);

  logic [ACC_WIDTH-1:0] new_num, new_den;
  logic                 ovf_all;
  logic [1:0]           err_next;

  always_comb begin
    if (znum) begin
      new_num = '0;
      new_den = '1;
      ovf_all = ovf;
    end else begin
      new_num = enc_n[ACC_WIDTH-1:0];
      new_den = enc_d[ACC_WIDTH-1:0];
      ovf_all = ovf | enc_n[ACC_WIDTH] | enc_d[ACC_WIDTH];
    end
    if (zden || err == fpr_pkg::ERR_ZERO) begin
      err_next = fpr_pkg::ERR_ZERO;
    end else if (ovf_all) begin
      err_next = fpr_pkg::ERR_OVF;
    end else begin
      err_next = err;
    end
  end

  // running product and status
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= ACC_WIDTH'(1);
      acc_den <= ACC_WIDTH'(1);
      err     <= fpr_pkg::ERR_NONE;
    end else if (cmd.commit) begin
      if (lastf) begin
        acc_num <= ACC_WIDTH'(1);
        acc_den <= ACC_WIDTH'(1);
        err     <= fpr_pkg::ERR_NONE;
      end else begin
        acc_num <= new_num;
        acc_den <= new_den;
        err     <= err_next;
      end
    end
  end

  // shift-add multipliers, counter, divider and gcd registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcn   <= PW'(anm);
      mcd   <= PW'(adm);
      mpn   <= fnm;
      mpd   <= fdm;
      prn   <= '0;
      prd   <= '0;
      sgn_n <= an_neg ^ fn_neg;
      sgn_d <= ad_neg ^ fd_neg;
      zden  <= (fdm == '0);
      znum  <= (anm == '0) || (fnm == '0);
      lastf <= in_last;
      ovf   <= 1'b0;
      cnt   <= '0;
    end
    if (cmd.mul_step) begin
      if (mpn[0]) prn <= prn + mcn;
      if (mpd[0]) prd <= prd + mcd;
      mcn <= mcn << 1;
      mcd <= mcd << 1;
      mpn <= mpn >> 1;
      mpd <= mpd >> 1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.gcd_load) begin
      ga  <= cpn;
      gb  <= cpd;
      gk  <= '0;
      qn  <= cpn;
      qd  <= cpd;
      rn  <= '0;
      rd  <= '0;
      ovf <= cap_n | cap_d;
      cnt <= '0;
    end
    if (cmd.gcd_step) begin
      if (ga == '0) begin
        g <= gb << gk;
      end else if (gb == '0) begin
        g <= ga << gk;
      end else if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        gk <= gk + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.div_step) begin
      {rn, qn} <= dvn;
      {rd, qd} <= dvd;
      cnt      <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gdone <= 1'b0;
    end else if (cmd.gcd_load) begin
      gdone <= 1'b0;
    end else if (cmd.gcd_step && (ga == '0 || gb == '0)) begin
      gdone <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && lastf) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && lastf) begin
      out_num    <= new_num;
      out_den    <= new_den;
      out_status <= err_next;
    end
  end

  assign sts.mul_last = (cnt == CW'(FACTOR_WIDTH - 1));
  assign sts.zero_num = znum;
  assign sts.gcd_done = gdone;
  assign sts.div_last = (cnt == CW'(GW - 1));
  assign sts.last     = lastf;
  assign sts.out_busy = out_valid && !out_ready;

  `FPR_ASSERT_IMP(a_no_overwrite, cmd.commit && lastf, !(out_valid && !out_ready))
  `FPR_ASSERT_IMP(a_gcd_operand, cmd.gcd_step, ga != '0 || gb != '0)
  `FPR_ASSERT_IMP(a_divisor_nonzero, cmd.div_step, g != '0)
  `FPR_ASSERT_NXT(a_restart, cmd.commit && lastf,
                  acc_num == ACC_WIDTH'(1) && acc_den == ACC_WIDTH'(1) &&
                  err == fpr_pkg::ERR_NONE)

endmodule
`default_nettype wire

// ===== src/fraction_product_reducer.sv =====
// Fraction product reducer: multiplies a run of signed fractions into a
// running product that starts at 1/1 and keeps it reduced by the gcd.
// Input stream s_axis: one word per fraction, numerator in the low half of
// tdata and denominator above it; tlast marks the final fraction of a run.
// Output stream m_axis: one word per run, reduced numerator and denominator
// in tdata and the status code in tuser (0 ok, 1 overflow saturated, 2 zero
// denominator seen). After the final word the product returns to 1/1.
// Each word passes through an accept state, a shift-add multiply, a cap
// step, a binary gcd of one shift or subtract per cycle plus a hand-over
// step (data dependent), a restoring division of both product magnitudes
// by the gcd and a commit state. A word whose product numerator is zero
// skips the gcd and the division.
// s_axis_tready is high only while the block is idle, one word at a time.
// The result sits in an output register, so a stalled receiver does not
// hold up the next run until that run's final word needs the register.
// Reset (rst, synchronous) returns the product to 1/1, clears the status
// and drops any pending output word.
`default_nettype none
module fraction_product_reducer #(
  parameter int FACTOR_WIDTH = fpr_pkg::FACTOR_WIDTH,
  parameter int ACC_WIDTH    = fpr_pkg::ACC_WIDTH,
  localparam int IN_TW       = ((2 * FACTOR_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW      = ((2 * ACC_WIDTH + 7) / 8) * 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [IN_TW-1:0]  s_axis_tdata,  // factor_numerator, factor_denominator
  input  wire               s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,  // product_num_out, product_den_out
  output logic [1:0]        m_axis_tuser   // status
);

  fpr_pkg::cmd_t cmd;
  fpr_pkg::sts_t sts;

  logic [ACC_WIDTH-1:0] out_num, out_den;

  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpr_dp #(
    .FACTOR_WIDTH (FACTOR_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_num     (s_axis_tdata[FACTOR_WIDTH-1:0]),
    .in_den     (s_axis_tdata[2*FACTOR_WIDTH-1:FACTOR_WIDTH]),
    .in_last    (s_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_num    (out_num),
    .out_den    (out_den),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TW'({out_den, out_num});

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;

  localparam int FACTOR_WIDTH = fpr_pkg::FACTOR_WIDTH;
  localparam int ACC_WIDTH    = fpr_pkg::ACC_WIDTH;
  localparam int IN_W   = ((2 * FACTOR_WIDTH + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * ACC_WIDTH + 7) / 8) * 8;
  localparam int LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 600;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] num;
    logic [ACC_WIDTH-1:0] den;
    fpr_pkg::err_t        status;
  } product_t;

  // Running fraction product predictor and the queue of products still to come.
  class run_scoreboard;
    logic [ACC_WIDTH-1:0] acc_num;
    logic [ACC_WIDTH-1:0] acc_den;
    fpr_pkg::err_t        err_code;
    product_t             exp_q[$];
    int errors;
    int checked;
    int words;
    int runs;
    int n_ovf;
    int n_zero;

    function new();
      clear_product();
      errors = 0;
      checked = 0;
      words = 0;
      runs = 0;
      n_ovf = 0;
      n_zero = 0;
    endfunction

    function void clear_product();
      acc_num  = 1;
      acc_den  = 1;
      err_code = fpr_pkg::ERR_NONE;
    endfunction

    function logic [63:0] split_sign(logic [63:0] sext, output bit neg);
      neg = sext[63];
      return neg ? (64'd0 - sext) : sext;
    endfunction

    function logic [63:0] mul_capped(logic [63:0] a, logic [63:0] b, inout bit ovf);
      if (b != 0 && a > fpr_pkg::CAP64 / b) begin
        ovf = 1'b1;
        return fpr_pkg::CAP64;
      end
      return a * b;
    endfunction

    function logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function logic [ACC_WIDTH-1:0] saturate(logic [63:0] mag, bit neg, inout bit ovf);
      logic [63:0] lim;
      lim = (64'd1 << (ACC_WIDTH - 1)) - 64'd1;
      if (mag > lim) begin
        mag = lim;
        ovf = 1'b1;
      end
      return ACC_WIDTH'(neg ? (64'd0 - mag) : mag);
    endfunction

    function void note_input(logic [FACTOR_WIDTH-1:0] fnum, logic [FACTOR_WIDTH-1:0] fden,
                             logic last);
      bit an, ad, fn, fd;
      bit ovf;
      logic [63:0] anm, adm, fnm, fdm, pn, pd, g;
      product_t p;
      ovf = 1'b0;
      anm = split_sign(64'($signed(acc_num)), an);
      adm = split_sign(64'($signed(acc_den)), ad);
      fnm = split_sign(64'($signed(fnum)), fn);
      fdm = split_sign(64'($signed(fden)), fd);
      words++;
      if (fdm == 0) err_code = fpr_pkg::ERR_ZERO;
      pn = mul_capped(anm, fnm, ovf);
      pd = mul_capped(adm, fdm, ovf);
      if (pn == 0) begin
        // zero product is always 0/-1
        acc_num = '0;
        acc_den = '1;
      end else begin
        g  = gcd_of(pn, pd);
        pn = pn / g;
        pd = pd / g;
        acc_num = saturate(pn, an != fn, ovf);
        acc_den = saturate(pd, ad != fd, ovf);
      end
      if (ovf && err_code != fpr_pkg::ERR_ZERO) err_code = fpr_pkg::ERR_OVF;
      if (last) begin
        p.num = acc_num;
        p.den = acc_den;
        p.status = err_code;
        exp_q.insert(exp_q.size(), p);
        runs++;
        if (err_code == fpr_pkg::ERR_OVF) n_ovf++;
        if (err_code == fpr_pkg::ERR_ZERO) n_zero++;
        clear_product();
      end
    endfunction

    function void check_result(logic [ACC_WIDTH-1:0] num, logic [ACC_WIDTH-1:0] den,
                               logic [1:0] status);
      product_t p;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected product word: num %h den %h status %0d",
                 $time, num, den, status);
        errors++;
        return;
      end
      p = exp_q.pop_front();
      checked++;
      if (num !== p.num) begin
        $display("%0t: numerator mismatch: expected %h actual %h", $time, p.num, num);
        errors++;
      end
      if (den !== p.den) begin
        $display("%0t: denominator mismatch: expected %h actual %h", $time, p.den, den);
        errors++;
      end
      if (status !== p.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, p.status, status);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  wire              s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  wire              m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  wire  [OUT_W-1:0] m_axis_tdata;
  wire  [1:0]       m_axis_tuser;

  run_scoreboard sb;
  int cycle_count = 0;
  int results_seen = 0;

  fraction_product_reducer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d products still pending", $time, sb.exp_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[ACC_WIDTH-1:0], m_axis_tdata[2*ACC_WIDTH-1:ACC_WIDTH],
                      m_axis_tuser);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: random ready pattern, plus one long hold so the block backs up
  initial begin
    bit held;
    int r;
    int n;
    held = 1'b0;
    forever begin
      if (!held && results_seen >= 15) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          m_axis_tready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 90) begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          n = $urandom_range(20, 100);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // many small parts so runs reduce and stay in range, some full-width and edge values
  function automatic logic [FACTOR_WIDTH-1:0] rand_part();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return FACTOR_WIDTH'($urandom_range(0, 24) - 12);
    if (r < 16) return FACTOR_WIDTH'($urandom);
    if (r < 19) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(FACTOR_WIDTH-1){1'b0}}};
        1: return {1'b0, {(FACTOR_WIDTH-1){1'b1}}};
        2: return '1;
        default: return FACTOR_WIDTH'(1);
      endcase
    end
    return '0;
  endfunction

  task automatic send_factor(input logic [FACTOR_WIDTH-1:0] num,
                             input logic [FACTOR_WIDTH-1:0] den, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({den, num});
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(num, den, last);
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int sent;
    int run_len;
    logic [FACTOR_WIDTH-1:0] fmin, fmax;
    sb = new();
    fmin = {1'b1, {(FACTOR_WIDTH-1){1'b0}}};
    fmax = {1'b0, {(FACTOR_WIDTH-1){1'b1}}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_factor(1, 1, 1);
    send_factor(6, 4, 1);
    send_factor(fmin, fmax, 0);
    send_factor(fmax, fmin, 1);
    send_factor(0, 5, 1);
    send_factor(0, 0, 1);
    // nonzero over zero reduces to +-1/0 and the zero sticks
    send_factor(7, 0, 0);
    send_factor(3, 2, 1);
    send_factor(fmax, 1, 0);
    send_factor(fmax, 1, 0);
    send_factor(fmax, 1, 1);
    send_factor(fmin, 1, 0);
    send_factor(fmin, 1, 0);
    send_factor(fmin, 1, 0);
    send_factor(1, fmin, 1);
    // a zero denominator keeps the product at 1/0, so the large factors that follow never saturate
    send_factor(fmax, 0, 0);
    send_factor(fmax, 0, 0);
    send_factor(fmax, 0, 1);
    send_factor(1, fmax, 0);
    send_factor(1, fmax, 0);
    send_factor(1, fmax, 1);
    send_factor(5, 3, 0);
    send_factor(3, 5, 1);
    send_factor('1, '1, 1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i < run_len; i++) begin
        send_factor(rand_part(), rand_part(), i == run_len - 1);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d fraction words in %0d runs, checked %0d products",
             sb.words, sb.runs, sb.checked);
    $display("Products with saturation: %0d, with a zero denominator: %0d",
             sb.n_ovf, sb.n_zero);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
